FILE: sv/ipd_pkg.sv
package ipd_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned WinW   = 16;
  localparam int unsigned CntW   = 6;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;

  // Bits per frame, 1 to 32
  localparam int unsigned DataBits = 32;

  // Item kinds
  typedef enum logic {
    KindEdge  = 1'b0,
    KindRearm = 1'b1
  } kind_e;

  // Register indexes (word address)
  typedef enum logic [2:0] {
    RegOneMin    = 3'd0,
    RegOneMax    = 3'd1,
    RegZeroMin   = 3'd2,
    RegZeroMax   = 3'd3,
    RegRepeatMin = 3'd4,
    RegRepeatMax = 3'd5
  } reg_idx_e;

  // Reset values of the period windows, microseconds
  localparam logic [WinW-1:0] OneMinRst    = 16'd2000;
  localparam logic [WinW-1:0] OneMaxRst    = 16'd2500;
  localparam logic [WinW-1:0] ZeroMinRst   = 16'd900;
  localparam logic [WinW-1:0] ZeroMaxRst   = 16'd1400;
  localparam logic [WinW-1:0] RepeatMinRst = 16'd11000;
  localparam logic [WinW-1:0] RepeatMaxRst = 16'd11500;

  typedef struct packed {
    logic [WinW-1:0] one_min;
    logic [WinW-1:0] one_max;
    logic [WinW-1:0] zero_min;
    logic [WinW-1:0] zero_max;
    logic [WinW-1:0] repeat_min;
    logic [WinW-1:0] repeat_max;
  } cfg_t;

  // Window hits for one period
  typedef struct packed {
    logic hit_one;
    logic hit_zero;
    logic hit_repeat;
  } win_t;

endpackage

FILE: sv/ipd_edge_if.sv
interface ipd_edge_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ipd_pkg::TimeW-1:0]   edge_time_us;

  modport source (output valid, output kind, output edge_time_us, input ready);
  modport sink   (input valid, input kind, input edge_time_us, output ready);
endinterface

FILE: sv/ipd_code_if.sv
interface ipd_code_if;
  logic                        valid;
  logic                        ready;
  logic [ipd_pkg::CodeW-1:0]   code;
  logic                        is_repeat;

  modport source (output valid, output code, output is_repeat, input ready);
  modport sink   (input valid, input code, input is_repeat, output ready);
endinterface

FILE: sv/ir_pulse_distance_decoder.sv
// Channel     Dir  Payload                        Beat
// edge_in_i   in   kind, edge_time_us             valid && ready
// code_out_o  out  code, is_repeat                valid && ready
// apb         in   6 x 16-bit period windows      psel && penable && pwrite
//
// One item per cycle while the result is not stalled: the beat lands in an input
// register, from which one subtract and three window compares update the state
// and load the result register.
// Reset clears the decode state and loads the default windows; no clearing pass.
// A stalled result blocks the input stage only when its item has a result.
module ir_pulse_distance_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ipd_edge_if.sink                    edge_in_i,
  ipd_code_if.source                  code_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipd_pkg::AddrW-1:0]   paddr,
  input  logic [ipd_pkg::DataW-1:0]   pwdata,
  output logic [ipd_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import ipd_pkg::*;

  cfg_t              cfg;
  win_t              win;

  // Input stage
  logic              s1_valid_q, s1_valid_d;
  logic              s1_kind_q;
  logic [TimeW-1:0]  s1_time_q;

  // Decode state
  logic [TimeW-1:0]  last_q, last_d;
  logic [CodeW-1:0]  shift_q, shift_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              proc_on_q, proc_on_d;

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [CodeW-1:0]  out_code_q;
  logic              out_rep_q;

  logic [TimeW-1:0]  period;
  logic              is_edge, act, take_bit, rep, full, emit;
  logic [CntW-1:0]   cnt_next;
  logic              out_free, s1_adv, in_beat;

  ipd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign period = s1_time_q - last_q;

  ipd_classify u_classify (
    .period_i (period),
    .cfg_i    (cfg),
    .win_o    (win)
  );

  // Sort the period; the one window wins over zero, zero over repeat
  always_comb begin
    is_edge  = (s1_kind_q == KindEdge);
    act      = is_edge && proc_on_q;
    take_bit = win.hit_one || win.hit_zero;
    rep      = !take_bit && win.hit_repeat;
    cnt_next = take_bit ? cnt_q + CntW'(1) : cnt_q;
    full     = !rep && (cnt_next == CntW'(DataBits));
    emit     = act && (rep || full);
  end

  // Handshake: hold the input stage only when its result cannot be loaded
  assign out_free        = !out_valid_q || code_out_o.ready;
  assign s1_adv          = s1_valid_q && (!emit || out_free);
  assign edge_in_i.ready = !s1_valid_q || s1_adv;
  assign in_beat         = edge_in_i.valid && edge_in_i.ready;

  // Next decode state
  always_comb begin
    last_d    = last_q;
    shift_d   = shift_q;
    cnt_d     = cnt_q;
    proc_on_d = proc_on_q;
    if (s1_adv) begin
      if (!is_edge) begin
        proc_on_d = 1'b1;
      end else if (proc_on_q) begin
        last_d = s1_time_q;
        if (take_bit) begin
          shift_d = {shift_q[CodeW-2:0], win.hit_one};
        end
        if (rep || full) begin
          cnt_d     = '0;
          proc_on_d = 1'b0;
        end else begin
          cnt_d = cnt_next;
        end
      end
    end
  end

  assign s1_valid_d  = in_beat || (s1_valid_q && !s1_adv);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && emit) begin
      out_valid_d = 1'b1;
    end else if (code_out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      shift_q     <= '0;
      cnt_q       <= '0;
      proc_on_q   <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      shift_q     <= shift_d;
      cnt_q       <= cnt_d;
      proc_on_q   <= proc_on_d;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_kind_q <= edge_in_i.kind;
      s1_time_q <= edge_in_i.edge_time_us;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_code_q <= shift_d;
      out_rep_q  <= rep;
    end
  end

  assign code_out_o.valid     = out_valid_q;
  assign code_out_o.code      = out_code_q;
  assign code_out_o.is_repeat = out_rep_q;

  // Emitting a result always stops processing
  a_emit_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && emit |=> !proc_on_q)
    else $error("processing still on after a result");

  // Bit count never reaches the frame length between items
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(DataBits))
    else $error("bit count out of range");

  // An edge seen while stopped gives no result and keeps the edge time
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && is_edge && !proc_on_q |-> !emit ##1 $stable(last_q))
    else $error("edge acted on while stopped");

endmodule

FILE: sv/ipd_cfg.sv
module ipd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipd_pkg::AddrW-1:0]   paddr,
  input  logic [ipd_pkg::DataW-1:0]   pwdata,
  output logic [ipd_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ipd_pkg::cfg_t               cfg_o
);
  import ipd_pkg::*;

  cfg_t             cfg_q;
  cfg_t             cfg_d;
  logic [2:0]       idx;
  logic             wr_en;
  logic [WinW-1:0]  wval;
  logic [WinW-1:0]  rval;

  assign idx   = paddr[AddrW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign wval  = pwdata[WinW-1:0];
  assign pready = 1'b1;

  // Decode the write beat
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegOneMin:    cfg_d.one_min    = wval;
        RegOneMax:    cfg_d.one_max    = wval;
        RegZeroMin:   cfg_d.zero_min   = wval;
        RegZeroMax:   cfg_d.zero_max   = wval;
        RegRepeatMin: cfg_d.repeat_min = wval;
        RegRepeatMax: cfg_d.repeat_max = wval;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_min    <= OneMinRst;
      cfg_q.one_max    <= OneMaxRst;
      cfg_q.zero_min   <= ZeroMinRst;
      cfg_q.zero_max   <= ZeroMaxRst;
      cfg_q.repeat_min <= RepeatMinRst;
      cfg_q.repeat_max <= RepeatMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      RegOneMin:    rval = cfg_q.one_min;
      RegOneMax:    rval = cfg_q.one_max;
      RegZeroMin:   rval = cfg_q.zero_min;
      RegZeroMax:   rval = cfg_q.zero_max;
      RegRepeatMin: rval = cfg_q.repeat_min;
      RegRepeatMax: rval = cfg_q.repeat_max;
      default:      rval = '0;
    endcase
  end

  assign prdata = {{(DataW-WinW){1'b0}}, rval};
  assign cfg_o  = cfg_q;

endmodule

FILE: sv/ipd_classify.sv
module ipd_classify (
  input  logic [ipd_pkg::TimeW-1:0] period_i,
  input  ipd_pkg::cfg_t             cfg_i,
  output ipd_pkg::win_t             win_o
);
  import ipd_pkg::*;

  // Inclusive window compares, zero-extended limits
  function automatic logic in_win(logic [TimeW-1:0] p, logic [WinW-1:0] lo,
                                  logic [WinW-1:0] hi);
    logic [TimeW-1:0] lo_x;
    logic [TimeW-1:0] hi_x;
    lo_x = {{(TimeW-WinW){1'b0}}, lo};
    hi_x = {{(TimeW-WinW){1'b0}}, hi};
    return (p >= lo_x) && (p <= hi_x);
  endfunction

  assign win_o.hit_one    = in_win(period_i, cfg_i.one_min, cfg_i.one_max);
  assign win_o.hit_zero   = in_win(period_i, cfg_i.zero_min, cfg_i.zero_max);
  assign win_o.hit_repeat = in_win(period_i, cfg_i.repeat_min, cfg_i.repeat_max);

endmodule
